// ----- hdl/utf8_to_utf16_decoder_unit_defines.svh -----
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define U8U16_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/u8u16_pkg.sv -----
package u8u16_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        bad_input;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [20:0] partial_point;
    logic [1:0]  bytes_remaining;
    logic [1:0]  sequence_length;
    logic        error_seen;
  } state_t;

  typedef struct packed {
    logic not_empty;
    logic room;
  } q_status_t;

  localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
  localparam logic [20:0] CP_MIN2      = 21'h000080;
  localparam logic [20:0] CP_MIN3      = 21'h000800;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST   = 21'h00D800;
  localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  localparam out_item_t ERR_STATUS = '{code_unit: 16'h0000, unit_valid: 1'b0,
                                       bad_input: 1'b1, last: 1'b1};

endpackage

// ----- hdl/u8u16_decode.sv -----
module u8u16_decode (
  input  u8u16_pkg::state_t    st,
  input  u8u16_pkg::in_item_t  item,
  output u8u16_pkg::state_t    st_next,
  output logic [1:0]           n_res,
  output u8u16_pkg::out_item_t res0,
  output u8u16_pkg::out_item_t res1
);
  import u8u16_pkg::*;

  logic [7:0]  b;
  logic [20:0] cp;
  logic [20:0] adj;
  logic        err;
  logic        bad_point;

  assign b   = item.byte_value;
  assign cp  = {st.partial_point[14:0], b[5:0]};
  assign adj = cp - CP_SUPP_BASE;

  assign bad_point = (st.sequence_length == SEQ_TWO && cp < CP_MIN2) ||
                     (st.sequence_length == SEQ_THREE && cp < CP_MIN3) ||
                     (st.sequence_length == SEQ_FOUR && cp < CP_SUPP_BASE) ||
                     (cp > CP_MAX) ||
                     (cp >= SURR_FIRST && cp <= SURR_LAST);

  always_comb begin
    st_next = st;
    err     = 1'b0;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    if (!st.error_seen) begin
      if (st.bytes_remaining == 2'd0) begin
        unique casez (b)
          8'b0???????: begin
            n_res           = 2'd1;
            res0.code_unit  = {8'h00, b};
            res0.unit_valid = 1'b1;
          end
          8'b110?????: begin
            if (b < LEAD2_MIN) begin
              err = 1'b1;
            end else begin
              st_next.partial_point   = {16'h0000, b[4:0]};
              st_next.bytes_remaining = 2'd1;
              st_next.sequence_length = SEQ_TWO;
            end
          end
          8'b1110????: begin
            st_next.partial_point   = {17'h00000, b[3:0]};
            st_next.bytes_remaining = 2'd2;
            st_next.sequence_length = SEQ_THREE;
          end
          8'b11110???: begin
            st_next.partial_point   = {18'h00000, b[2:0]};
            st_next.bytes_remaining = 2'd3;
            st_next.sequence_length = SEQ_FOUR;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        st_next.partial_point   = cp;
        st_next.bytes_remaining = st.bytes_remaining - 2'd1;
        if (st.bytes_remaining == 2'd1) begin
          if (bad_point) begin
            err = 1'b1;
          end else if (cp <= CP_BMP_MAX) begin
            n_res           = 2'd1;
            res0.code_unit  = cp[15:0];
            res0.unit_valid = 1'b1;
          end else begin
            n_res           = 2'd2;
            res0.code_unit  = SURR_HI_BASE + {6'b000000, adj[19:10]};
            res0.unit_valid = 1'b1;
            res1.code_unit  = SURR_LO_BASE + {6'b000000, adj[9:0]};
            res1.unit_valid = 1'b1;
          end
        end
      end
      if (!err && item.end_of_string && st_next.bytes_remaining != 2'd0) begin
        err = 1'b1;
      end
      if (err) begin
        st_next.error_seen = 1'b1;
        n_res              = 2'd0;
      end
    end
    if (item.end_of_string) begin
      if (st_next.error_seen || n_res == 2'd0) begin
        n_res = 2'd1;
        res0  = ERR_STATUS;
        res1  = '0;
      end else if (n_res == 2'd1) begin
        res0.last = 1'b1;
      end else begin
        res1.last = 1'b1;
      end
      st_next = '0;
    end
  end

endmodule

// ----- hdl/u8u16_queue.sv -----
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  u8u16_pkg::out_item_t push0,
  input  u8u16_pkg::out_item_t push1,
  input  logic                 pop,
  output u8u16_pkg::out_item_t head,
  output u8u16_pkg::q_status_t status
);
  import u8u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr1;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_count == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr1);
      end else if (push_count == 2'd1) begin
        wr_ptr <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr1] <= push1;
    end
  end

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.room      = (count <= CNT_W'(DEPTH - 2));

endmodule

// ----- hdl/utf8_to_utf16_decoder_unit.sv -----
// Strict UTF-8 to UTF-16 transcoder. A byte enters an input register, is decoded in
// the following cycle and its zero, one or two results (two for a surrogate pair)
// go into a QUEUE_DEPTH-entry result queue whose head drives the result port, so
// a result passes the input register and the queue before it can be taken.
// Bytes are taken every cycle while the queue has room for two results; with
// results taken every cycle the input never stalls, since a surrogate pair only
// follows three bytes that give no result. After an invalid byte nothing is sent
// until the string's last byte, which brings one closing item with bad_input set;
// units already sent for that string must be dropped.
`include "utf8_to_utf16_decoder_unit_defines.svh"

module utf8_to_utf16_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  u8u16_pkg::in_item_t  byte_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output u8u16_pkg::out_item_t result_data
);
  import u8u16_pkg::*;

  logic      in_full;
  in_item_t  in_item;
  state_t    st;
  state_t    st_next;
  logic [1:0] n_res;
  out_item_t res0;
  out_item_t res1;
  q_status_t q_status;
  logic      process;
  logic [1:0] push_count;

  assign process    = in_full && q_status.room;
  assign byte_ready = !in_full || process;
  assign push_count = process ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      st      <= '0;
    end else begin
      if (byte_ready) begin
        in_full <= byte_valid;
      end
      if (process) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_item <= byte_data;
    end
  end

  u8u16_decode u_decode (
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .n_res   (n_res),
    .res0    (res0),
    .res1    (res1)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (result_valid && result_ready),
    .head       (result_data),
    .status     (q_status)
  );

  assign result_valid = q_status.not_empty;

  `U8U16_ASSERT_NEXT(a_push_shows, process && n_res != 2'd0, result_valid, "pushed item not visible")
  `U8U16_ASSERT_NOW(a_hold_stalls, in_full && !process, !byte_ready, "byte taken while held")
  `U8U16_ASSERT_NOW(a_err_shape, result_valid && result_data.bad_input, !result_data.unit_valid && result_data.last && result_data.code_unit == 16'h0000, "bad error status")
  `U8U16_ASSERT_NOW(a_no_empty, result_valid && !result_data.unit_valid, result_data.bad_input, "item with no unit and no error")

endmodule
